### design/orientation_delta_from_reference_unit_defines.svh
// Assertion macros shared by the orientation delta block.
`ifndef ORIENTATION_DELTA_FROM_REFERENCE_UNIT_DEFINES_SVH
`define ORIENTATION_DELTA_FROM_REFERENCE_UNIT_DEFINES_SVH

// Condition holds in the same cycle as the trigger.
`define ODR_ASSERT_SAME(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("assertion failed");

// Condition holds in the cycle after the trigger.
`define ODR_ASSERT_NEXT(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("assertion failed");

`endif

### design/odr_pkg.sv
`default_nettype none
package odr_pkg;

  // Width of the CORDIC x and y datapath and of the angle accumulator (degrees, Q16).
  localparam int CXW = 38;
  localparam int ZW  = 26;

  localparam logic signed [CXW-1:0] ONE_Q28    = CXW'(1) <<< 28;
  localparam logic signed [ZW-1:0]  DEG180_Q16 = ZW'(180) <<< 16;
  localparam logic signed [ZW-1:0]  DEG90_Q16  = ZW'(90) <<< 16;

  // Product schedule of the shared multiply-accumulate.
  typedef enum logic [3:0] {
    MAC_WX, MAC_YZ, MAC_XX_R, MAC_YY_R, MAC_WY, MAC_ZX,
    MAC_WZ, MAC_XY, MAC_YY_Y, MAC_ZZ
  } mac_step_t;

  typedef enum logic [1:0] {ANG_ROLL, ANG_PITCH, ANG_YAW} angle_sel_t;

  // Rounded atan(2^-i) in degrees, Q16.
  function automatic logic [21:0] atan_q16(input logic [4:0] i);
    logic [21:0] v;
    case (i)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117304;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

### design/orientation_delta_from_reference_unit.sv
// Channel | Dir | Handshake          | Payload
// s_*     | in  | s_tvalid/s_tready  | s_tdata: position triple and quaternion; s_tuser: capture
// m_*     | out | m_tvalid/m_tready  | m_tdata: position and angle differences
//
// The block takes one request at a time: it accepts the next only after the result of the
// last is loaded into the output register, which a stalled output holds back. A saturated pitch
// skips the square root and its CORDIC run, and an angle whose two operands are both zero
// skips its CORDIC run. The square root takes 29 steps; the three CORDIC runs share one
// CORDIC stage, and the quaternion products and the square of the pitch sine share one
// multiplier.
// rst is synchronous, active high; it clears the sequencer, the output valid and the
// stored reference. A stalled output holds its result; the block goes back to idle
// and takes the next request as soon as the result sits in the output register.
`default_nettype none
`include "orientation_delta_from_reference_unit_defines.svh"
module orientation_delta_from_reference_unit #(
  parameter int CORDIC_STEPS    = 16,
  parameter int ANGLE_FRAC_BITS = 7
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // ptz_x, ptz_y, ptz_z (24 each), quat_w, quat_x, quat_y, quat_z (16 each)
  input  wire logic [135:0] s_tdata,
  // capture_reference
  input  wire logic [0:0]   s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // ptz_dx, ptz_dy, ptz_dz (24 each), roll_delta, pitch_delta, yaw_delta (16 each)
  output logic [119:0]      m_tdata
);

  localparam int CXW     = odr_pkg::CXW;
  localparam int ZW      = odr_pkg::ZW;
  localparam int ANGLE_W = ANGLE_FRAC_BITS + 10;
  localparam int SH      = 16 - ANGLE_FRAC_BITS;
  localparam int CW      = $clog2(CORDIC_STEPS);
  localparam logic [CW-1:0] LAST_IT = CW'(CORDIC_STEPS - 1);
  localparam logic signed [ZW-1:0] HALF = ZW'(1) <<< (SH - 1);
  localparam logic [56:0] RAD_ONE = 57'(1) << 56;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MAC, ST_SQR, ST_ROOT, ST_SETUP, ST_ITER, ST_FINISH, ST_OUT
  } state_t;

  state_t state;
  odr_pkg::mac_step_t k;
  odr_pkg::angle_sel_t sel;

  logic                    cap;
  logic signed [23:0]      px, py, pz;
  logic signed [15:0]      qw, qx, qy, qz;
  logic signed [32:0]      acc_sr, acc_cr, acc_sp, acc_sy, acc_cy;
  logic [56:0]             rad;
  logic [57:0]             res;
  logic [4:0]              j;
  logic signed [CXW-1:0]   cx, cy;
  logic signed [ZW-1:0]    cz;
  logic [CW-1:0]           it;
  logic signed [ANGLE_W-1:0] roll_a, pitch_a, yaw_a;
  logic signed [23:0]      ref_x, ref_y, ref_z;
  logic signed [ANGLE_W-1:0] ref_roll, ref_pitch, ref_yaw;

  // Shared multiplier.
  logic signed [29:0] mul_a, mul_b;
  logic signed [59:0] mul_p;
  logic signed [32:0] term;
  logic               term_sub;

  logic signed [CXW-1:0] sinr, cosr, sinp, siny, cosy;
  logic                  sat_pos, sat_neg;

  assign sinr = CXW'(acc_sr) <<< 1;
  assign cosr = (CXW'(acc_cr) <<< 1) + odr_pkg::ONE_Q28;
  assign sinp = CXW'(acc_sp) <<< 1;
  assign siny = CXW'(acc_sy) <<< 1;
  assign cosy = (CXW'(acc_cy) <<< 1) + odr_pkg::ONE_Q28;
  assign sat_pos = sinp >= odr_pkg::ONE_Q28;
  assign sat_neg = sinp <= -odr_pkg::ONE_Q28;

  always_comb begin
    mul_a = 30'(qw);
    mul_b = 30'(qx);
    term_sub = 1'b0;
    if (state == ST_SQR) begin
      mul_a = 30'(sinp);
      mul_b = 30'(sinp);
    end else begin
      case (k)
        odr_pkg::MAC_WX:   begin mul_a = 30'(qw); mul_b = 30'(qx); end
        odr_pkg::MAC_YZ:   begin mul_a = 30'(qy); mul_b = 30'(qz); end
        odr_pkg::MAC_XX_R: begin mul_a = 30'(qx); mul_b = 30'(qx); term_sub = 1'b1; end
        odr_pkg::MAC_YY_R: begin mul_a = 30'(qy); mul_b = 30'(qy); term_sub = 1'b1; end
        odr_pkg::MAC_WY:   begin mul_a = 30'(qw); mul_b = 30'(qy); end
        odr_pkg::MAC_ZX:   begin mul_a = 30'(qz); mul_b = 30'(qx); term_sub = 1'b1; end
        odr_pkg::MAC_WZ:   begin mul_a = 30'(qw); mul_b = 30'(qz); end
        odr_pkg::MAC_XY:   begin mul_a = 30'(qx); mul_b = 30'(qy); end
        odr_pkg::MAC_YY_Y: begin mul_a = 30'(qy); mul_b = 30'(qy); term_sub = 1'b1; end
        odr_pkg::MAC_ZZ:   begin mul_a = 30'(qz); mul_b = 30'(qz); term_sub = 1'b1; end
        default: ;
      endcase
    end
  end

  assign mul_p = mul_a * mul_b;
  assign term  = term_sub ? -mul_p[32:0] : mul_p[32:0];

  // Square root step: one result bit per cycle.
  logic [57:0] root_bit, root_trial;
  logic        root_take;
  assign root_bit   = 58'(1) << {j, 1'b0};
  assign root_trial = res + root_bit;
  assign root_take  = {1'b0, rad} >= root_trial;

  // CORDIC operand selection for the setup cycle.
  logic signed [CXW-1:0] op_y, op_x;
  always_comb begin
    case (sel)
      odr_pkg::ANG_ROLL:  begin op_y = sinr; op_x = cosr; end
      odr_pkg::ANG_PITCH: begin op_y = sinp; op_x = signed'(CXW'(res)); end
      default:            begin op_y = siny; op_x = cosy; end
    endcase
  end

  // One CORDIC vectoring step.
  logic signed [CXW-1:0] xs, ys;
  logic signed [ZW-1:0]  tv;
  assign xs = cx >>> it;
  assign ys = cy >>> it;
  assign tv = signed'(ZW'(odr_pkg::atan_q16(5'(it))));

  // Clamp to half a turn, round half up to the output fraction.
  logic signed [ZW-1:0]      zc, zr;
  logic signed [ANGLE_W-1:0] units;
  always_comb begin
    zc = cz;
    if (cz > odr_pkg::DEG180_Q16) zc = odr_pkg::DEG180_Q16;
    if (cz < -odr_pkg::DEG180_Q16) zc = -odr_pkg::DEG180_Q16;
    zr = zc + HALF;
    units = ANGLE_W'(zr >>> SH);
  end

  function automatic logic [23:0] pos_delta(input logic signed [23:0] a,
                                            input logic signed [23:0] b);
    logic signed [24:0] d;
    d = 25'(a) - 25'(b);
    return d[24] ? 24'(-d) : d[23:0];
  endfunction

  function automatic logic [15:0] ang_delta(input logic signed [ANGLE_W-1:0] a,
                                            input logic signed [ANGLE_W-1:0] b);
    logic signed [ANGLE_W:0] d;
    logic [31:0] m;
    d = (ANGLE_W+1)'(a) - (ANGLE_W+1)'(b);
    m = d[ANGLE_W] ? 32'(-d) : 32'(d);
    return (m > 32'd65535) ? 16'hFFFF : m[15:0];
  endfunction

  // Reference actually used: a capture compares the sample with itself.
  logic signed [23:0]        use_x, use_y, use_z;
  logic signed [ANGLE_W-1:0] use_roll, use_pitch, use_yaw;
  logic                      load_out;
  assign use_x     = cap ? px : ref_x;
  assign use_y     = cap ? py : ref_y;
  assign use_z     = cap ? pz : ref_z;
  assign use_roll  = cap ? roll_a : ref_roll;
  assign use_pitch = cap ? pitch_a : ref_pitch;
  assign use_yaw   = cap ? yaw_a : ref_yaw;
  assign load_out  = (state == ST_OUT) && (!m_tvalid || m_tready);

  assign s_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      m_tvalid  <= 1'b0;
      ref_x     <= '0;
      ref_y     <= '0;
      ref_z     <= '0;
      ref_roll  <= '0;
      ref_pitch <= '0;
      ref_yaw   <= '0;
      k         <= odr_pkg::MAC_WX;
      sel       <= odr_pkg::ANG_ROLL;
    end else begin
      if (m_tvalid && m_tready && !load_out) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            cap    <= s_tuser[0];
            px     <= s_tdata[23:0];
            py     <= s_tdata[47:24];
            pz     <= s_tdata[71:48];
            qw     <= s_tdata[87:72];
            qx     <= s_tdata[103:88];
            qy     <= s_tdata[119:104];
            qz     <= s_tdata[135:120];
            acc_sr <= '0;
            acc_cr <= '0;
            acc_sp <= '0;
            acc_sy <= '0;
            acc_cy <= '0;
            k      <= odr_pkg::MAC_WX;
            state  <= ST_MAC;
          end
        end
        ST_MAC: begin
          case (k)
            odr_pkg::MAC_WX, odr_pkg::MAC_YZ:     acc_sr <= acc_sr + term;
            odr_pkg::MAC_XX_R, odr_pkg::MAC_YY_R: acc_cr <= acc_cr + term;
            odr_pkg::MAC_WY, odr_pkg::MAC_ZX:     acc_sp <= acc_sp + term;
            odr_pkg::MAC_WZ, odr_pkg::MAC_XY:     acc_sy <= acc_sy + term;
            default:                              acc_cy <= acc_cy + term;
          endcase
          if (k == odr_pkg::MAC_ZZ) begin
            state <= ST_SQR;
          end else begin
            k <= odr_pkg::mac_step_t'(k + 4'd1);
          end
        end
        ST_SQR: begin
          rad <= RAD_ONE - mul_p[56:0];
          res <= '0;
          j   <= 5'd28;
          sel <= odr_pkg::ANG_ROLL;
          if (sat_pos || sat_neg) begin
            state <= ST_SETUP;
          end else begin
            state <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          if (root_take) begin
            rad <= rad - root_trial[56:0];
            res <= (res >> 1) + root_bit;
          end else begin
            res <= res >> 1;
          end
          j <= j - 5'd1;
          if (j == 5'd0) state <= ST_SETUP;
        end
        ST_SETUP: begin
          it <= '0;
          cx <= op_x;
          cy <= op_y;
          cz <= '0;
          if (sel == odr_pkg::ANG_PITCH && (sat_pos || sat_neg)) begin
            cz    <= sat_pos ? odr_pkg::DEG90_Q16 : -odr_pkg::DEG90_Q16;
            state <= ST_FINISH;
          end else if (op_x == '0 && op_y == '0) begin
            state <= ST_FINISH;
          end else begin
            if (op_x < 0) begin
              cz <= (op_y < 0) ? -odr_pkg::DEG180_Q16 : odr_pkg::DEG180_Q16;
              cx <= -op_x;
              cy <= -op_y;
            end
            state <= ST_ITER;
          end
        end
        ST_ITER: begin
          if (cy > 0) begin
            cx <= cx + ys;
            cy <= cy - xs;
            cz <= cz + tv;
          end else begin
            cx <= cx - ys;
            cy <= cy + xs;
            cz <= cz - tv;
          end
          it <= it + CW'(1);
          if (it == LAST_IT) state <= ST_FINISH;
        end
        ST_FINISH: begin
          case (sel)
            odr_pkg::ANG_ROLL:  roll_a  <= units;
            odr_pkg::ANG_PITCH: pitch_a <= units;
            default:            yaw_a   <= units;
          endcase
          if (sel == odr_pkg::ANG_YAW) begin
            state <= ST_OUT;
          end else begin
            sel   <= odr_pkg::angle_sel_t'(sel + 2'd1);
            state <= ST_SETUP;
          end
        end
        ST_OUT: begin
          if (load_out) begin
            m_tdata <= {ang_delta(yaw_a, use_yaw), ang_delta(pitch_a, use_pitch),
                        ang_delta(roll_a, use_roll), pos_delta(pz, use_z),
                        pos_delta(py, use_y), pos_delta(px, use_x)};
            m_tvalid <= 1'b1;
            if (cap) begin
              ref_x     <= px;
              ref_y     <= py;
              ref_z     <= pz;
              ref_roll  <= roll_a;
              ref_pitch <= pitch_a;
              ref_yaw   <= yaw_a;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // An accepted request makes the block busy, so it is not ready to take another.
  `ODR_ASSERT_NEXT(a_busy_after_request, s_tvalid && s_tready, !s_tready)
  // A capturing request reports zero difference everywhere.
  `ODR_ASSERT_NEXT(a_capture_zero, load_out && cap, m_tdata == '0)
  // The CORDIC step counter never runs past the table it walks.
  `ODR_ASSERT_SAME(a_iter_range, state == ST_ITER, it <= LAST_IT)

endmodule
`default_nettype wire
